### rtl/utlf_pkg.sv
// Shared constants, types and register codes for the ultrasonic tank level filter.
package utlf_pkg;

    localparam int AVERAGE_DEPTH = 5;

    localparam int ECHO_W     = 15;
    localparam int DIST_W     = 12;
    localparam int DIST_RAW_W = 13;
    localparam int HEIGHT_W   = 16;
    localparam int CAP_W      = 16;
    localparam int BAD_W      = 8;
    localparam int KIND_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int PCT_W      = 7;
    localparam int VOL_W      = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TANK_HEIGHT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TANK_CAPACITY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DISTANCE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DISTANCE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STREAK_LIMIT  = 3'd5;

    localparam logic [HEIGHT_W-1:0] HEIGHT_DEFAULT   = 16'd1500;
    localparam logic [CAP_W-1:0]    CAPACITY_DEFAULT = 16'd1000;
    localparam logic [DIST_W-1:0]   MIN_DIST_RESET   = 12'd20;
    localparam logic [DIST_W-1:0]   MAX_DIST_RESET   = 12'd4000;
    localparam logic [DIST_W-1:0]   MAX_STEP_RESET   = 12'd50;
    localparam logic [BAD_W-1:0]    STREAK_RESET     = 8'd10;
    localparam logic [BAD_W-1:0]    BAD_MAX          = 8'd255;

    localparam int ECHO_SCALE_W = 14;
    localparam logic [ECHO_SCALE_W-1:0] ECHO_SCALE = 14'd11239;
    localparam int ECHO_PROD_W  = ECHO_W + ECHO_SCALE_W;
    localparam logic [ECHO_PROD_W:0] ECHO_ROUND = 30'd32768;
    localparam int ECHO_SHIFT   = 16;

    localparam int RING_IDX_W = (AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH) : 1;
    localparam int FILL_W     = $clog2(AVERAGE_DEPTH + 1);
    localparam int SUM_W      = $clog2(AVERAGE_DEPTH * ((1 << DIST_W) - 1) + 1);

    localparam int DIV_REM_W = 16;
    localparam int DIV_LOW_W = DIST_W;
    localparam int DIV_CNT_W = $clog2(DIV_LOW_W + 1);
    localparam int PCT_STEPS = PCT_W;
    localparam logic [DIV_CNT_W-1:0] AVG_DIV_STEPS = DIV_CNT_W'(DIST_W);
    localparam logic [DIV_CNT_W-1:0] PCT_DIV_STEPS = DIV_CNT_W'(PCT_STEPS);

    localparam int LVL_W = 23;
    localparam logic [LVL_W-1:0] PCT_SCALE = 23'd100;

    localparam int VOL_PROD_W  = PCT_W + CAP_W;
    localparam int VOL_RECIP_W = 24;
    localparam logic [VOL_RECIP_W-1:0] VOL_RECIP = 24'd10737419;
    localparam int VOL_FULL_W  = VOL_PROD_W + VOL_RECIP_W;
    localparam int VOL_SHIFT   = 30;

    localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_STATUS = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FULL   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TIMEOUT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [DIST_W-1:0]   distance;
        logic [PCT_W-1:0]    pct;
        logic [VOL_W-1:0]    vol;
        logic [STATUS_W-1:0] status;
        logic                lamp;
    } result_t;

    typedef struct packed {
        logic load_in;
        logic mul_echo;
        logic check;
        logic take_avg;
        logic take_pct;
        logic mul_recip;
        logic finish;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic reject;
        logic above;
        logic div_busy;
        logic out_free;
    } dp_status_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] steps;
    } div_req_t;

endpackage

### rtl/utlf_div.sv
// Restoring divider that produces one quotient bit per cycle.
module utlf_div (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  utlf_pkg::div_req_t                 req,
    input  logic [utlf_pkg::DIV_REM_W-1:0]     rem_init,
    input  logic [utlf_pkg::DIV_LOW_W-1:0]     low_init,
    input  logic [utlf_pkg::DIV_REM_W-1:0]     divisor,
    output logic                               busy,
    output logic [utlf_pkg::DIV_LOW_W-1:0]     quotient
);
    import utlf_pkg::*;

    logic [DIV_REM_W-1:0] rem_reg;
    logic [DIV_LOW_W-1:0] low_reg;
    logic [DIV_LOW_W-1:0] quot_reg;
    logic [DIV_REM_W-1:0] divisor_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;

    logic [DIV_REM_W:0]   trial;
    logic                 fits;
    logic [DIV_REM_W:0]   diff;

    assign trial = {rem_reg, low_reg[DIV_LOW_W-1]};
    assign fits  = trial >= {1'b0, divisor_reg};
    assign diff  = trial - {1'b0, divisor_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (req.start) begin
            cnt_reg <= req.steps;
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg     <= rem_init;
            low_reg     <= low_init;
            quot_reg    <= '0;
            divisor_reg <= divisor;
        end else if (cnt_reg != '0) begin
            rem_reg  <= fits ? diff[DIV_REM_W-1:0] : trial[DIV_REM_W-1:0];
            low_reg  <= {low_reg[DIV_LOW_W-2:0], 1'b0};
            quot_reg <= {quot_reg[DIV_LOW_W-2:0], fits};
        end
    end

    assign busy     = cnt_reg != '0;
    assign quotient = quot_reg;

endmodule

### rtl/utlf_dpath.sv
// Datapath: configuration registers, filter state, arithmetic and the result registers.
module utlf_dpath (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wen,
    input  logic [utlf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [utlf_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic [utlf_pkg::ECHO_W-1:0]        s_echo_time,
    input  utlf_pkg::ctrl_cmd_t                cmd,
    output utlf_pkg::dp_status_t               sts,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [utlf_pkg::KIND_W-1:0]        m_update_kind,
    output logic [utlf_pkg::DIST_W-1:0]        m_distance_out,
    output logic [utlf_pkg::PCT_W-1:0]         m_level_percent,
    output logic [utlf_pkg::VOL_W-1:0]         m_volume_out,
    output logic [utlf_pkg::STATUS_W-1:0]      m_sensor_status,
    output logic                               m_good_lamp
);
    import utlf_pkg::*;

    logic [HEIGHT_W-1:0]    height_reg;
    logic [CAP_W-1:0]       capacity_reg;
    logic [DIST_W-1:0]      min_dist_reg;
    logic [DIST_W-1:0]      max_dist_reg;
    logic [DIST_W-1:0]      max_step_reg;
    logic [BAD_W-1:0]       streak_limit_reg;

    logic [ECHO_W-1:0]      echo_reg;
    logic [ECHO_PROD_W-1:0] prod_reg;
    logic [DIST_W-1:0]      ring_reg [AVERAGE_DEPTH];
    logic [RING_IDX_W-1:0]  slot_reg;
    logic [FILL_W-1:0]      fill_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [DIST_W-1:0]      last_good_reg;
    logic                   have_good_reg;
    logic [BAD_W-1:0]       bad_run_reg;
    logic [VOL_PROD_W-1:0]  pctmul_reg;
    logic [VOL_FULL_W-1:0]  recip_reg;
    result_t                res_reg;
    result_t                out_reg;
    logic                   m_valid_reg;

    logic [ECHO_PROD_W:0]         rounded;
    logic [DIST_RAW_W-1:0]        raw_dist;
    logic                         is_timeout;
    logic                         out_of_range;
    logic [DIST_RAW_W-1:0]        step_diff;
    logic                         too_far;
    logic                         reject;
    logic [STATUS_W-1:0]          rej_status;
    logic [BAD_W-1:0]             bad_run_next;
    logic                         quiet;
    logic                         fill_full;
    logic [FILL_W-1:0]            fill_next;
    logic [SUM_W-1:0]             sum_next;
    logic [RING_IDX_W-1:0]        slot_next;
    logic [DIST_W+DIV_REM_W-1:0]  sum_ext;
    logic [DIST_W-1:0]            avg;
    logic                         above;
    logic [HEIGHT_W-1:0]          lvl_diff;
    logic [LVL_W-1:0]             lvl_dividend;
    div_req_t                     div_req;
    logic [DIV_REM_W-1:0]         div_rem_init;
    logic [DIV_LOW_W-1:0]         div_low_init;
    logic [DIV_REM_W-1:0]         div_divisor;
    logic                         div_busy;
    logic [DIV_LOW_W-1:0]         quot;

    // The scaled echo rounds half up; the distance is the top of the product.
    assign rounded      = {1'b0, prod_reg} + ECHO_ROUND;
    assign raw_dist     = rounded[ECHO_SHIFT +: DIST_RAW_W];
    assign is_timeout   = echo_reg == '0;
    assign out_of_range = (raw_dist < {1'b0, min_dist_reg}) ||
                          (raw_dist > {1'b0, max_dist_reg});
    assign step_diff    = (raw_dist >= {1'b0, last_good_reg}) ? raw_dist - {1'b0, last_good_reg}
                                                             : {1'b0, last_good_reg} - raw_dist;
    assign too_far      = have_good_reg && (step_diff > {1'b0, max_step_reg});
    assign reject       = is_timeout || out_of_range || too_far;
    assign rej_status   = is_timeout ? ST_TIMEOUT : ST_INVALID;
    assign bad_run_next = (bad_run_reg == BAD_MAX) ? bad_run_reg : bad_run_reg + 1'b1;
    assign quiet        = have_good_reg && (bad_run_next < streak_limit_reg);

    // The running sum always equals the sum of the filled ring entries.
    assign fill_full = fill_reg == FILL_W'(AVERAGE_DEPTH);
    assign fill_next = fill_full ? fill_reg : fill_reg + 1'b1;
    assign sum_next  = sum_reg + SUM_W'(raw_dist[DIST_W-1:0])
                       - (fill_full ? SUM_W'(ring_reg[slot_reg]) : SUM_W'(0));
    assign slot_next = (slot_reg == RING_IDX_W'(AVERAGE_DEPTH - 1)) ? '0
                                                                  : slot_reg + 1'b1;
    assign sum_ext   = (DIST_W + DIV_REM_W)'(sum_next);

    assign avg          = quot;
    assign above        = {{(HEIGHT_W-DIST_W){1'b0}}, avg} > height_reg;
    assign lvl_diff     = height_reg - {{(HEIGHT_W-DIST_W){1'b0}}, avg};
    assign lvl_dividend = LVL_W'(lvl_diff) * PCT_SCALE;

    // The quotient width is known in advance, so the partial remainder starts with
    // the dividend bits above it and is already smaller than the divisor.
    always_comb begin
        div_req.start = (cmd.check && !reject) || (cmd.take_avg && !above);
        if (cmd.check) begin
            div_req.steps = AVG_DIV_STEPS;
            div_rem_init  = DIV_REM_W'(sum_ext >> DIST_W);
            div_low_init  = sum_ext[DIST_W-1:0];
            div_divisor   = DIV_REM_W'(fill_next);
        end else begin
            div_req.steps = PCT_DIV_STEPS;
            div_rem_init  = lvl_dividend[LVL_W-1:PCT_STEPS];
            div_low_init  = {lvl_dividend[PCT_STEPS-1:0], {(DIV_LOW_W-PCT_STEPS){1'b0}}};
            div_divisor   = height_reg;
        end
    end

    utlf_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .rem_init (div_rem_init),
        .low_init (div_low_init),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            height_reg       <= HEIGHT_DEFAULT;
            capacity_reg     <= CAPACITY_DEFAULT;
            min_dist_reg     <= MIN_DIST_RESET;
            max_dist_reg     <= MAX_DIST_RESET;
            max_step_reg     <= MAX_STEP_RESET;
            streak_limit_reg <= STREAK_RESET;
        end else if (cfg_wen) begin
            case (cfg_index)
                CFG_TANK_HEIGHT: begin
                    height_reg <= (cfg_wdata == '0) ? HEIGHT_DEFAULT : cfg_wdata;
                end
                CFG_TANK_CAPACITY: begin
                    capacity_reg <= (cfg_wdata == '0) ? CAPACITY_DEFAULT : cfg_wdata;
                end
                CFG_MIN_DISTANCE: begin
                    min_dist_reg <= cfg_wdata[DIST_W-1:0];
                end
                CFG_MAX_DISTANCE: begin
                    max_dist_reg <= cfg_wdata[DIST_W-1:0];
                end
                CFG_MAX_STEP: begin
                    max_step_reg <= cfg_wdata[DIST_W-1:0];
                end
                CFG_STREAK_LIMIT: begin
                    streak_limit_reg <= cfg_wdata[BAD_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg      <= '0;
            fill_reg      <= '0;
            sum_reg       <= '0;
            last_good_reg <= '0;
            have_good_reg <= 1'b0;
            bad_run_reg   <= '0;
        end else if (cmd.check) begin
            if (reject) begin
                bad_run_reg <= bad_run_next;
            end else begin
                slot_reg <= slot_next;
                fill_reg <= fill_next;
                sum_reg  <= sum_next;
            end
        end else if (cmd.take_avg) begin
            last_good_reg <= avg;
            have_good_reg <= 1'b1;
            bad_run_reg   <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            echo_reg <= s_echo_time;
        end
        if (cmd.mul_echo) begin
            prod_reg <= ECHO_PROD_W'(echo_reg) * ECHO_PROD_W'(ECHO_SCALE);
        end
        if (cmd.check && !reject) begin
            ring_reg[slot_reg] <= raw_dist[DIST_W-1:0];
        end
        if (cmd.take_pct) begin
            pctmul_reg <= VOL_PROD_W'(quot[PCT_W-1:0]) * VOL_PROD_W'(capacity_reg);
        end
        if (cmd.mul_recip) begin
            recip_reg <= VOL_FULL_W'(pctmul_reg) * VOL_FULL_W'(VOL_RECIP);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.check && reject) begin
            if (quiet) begin
                res_reg.kind     <= KIND_NONE;
                res_reg.distance <= '0;
                res_reg.status   <= ST_OK;
            end else begin
                res_reg.kind     <= have_good_reg ? KIND_STATUS : KIND_FULL;
                res_reg.distance <= last_good_reg;
                res_reg.status   <= rej_status;
            end
            res_reg.pct  <= '0;
            res_reg.vol  <= '0;
            res_reg.lamp <= 1'b0;
        end else if (cmd.take_avg) begin
            res_reg.kind     <= KIND_STATUS;
            res_reg.distance <= avg;
            res_reg.pct      <= '0;
            res_reg.vol      <= '0;
            res_reg.status   <= ST_INVALID;
            res_reg.lamp     <= 1'b1;
        end else if (cmd.take_pct) begin
            res_reg.pct <= quot[PCT_W-1:0];
        end else if (cmd.finish) begin
            res_reg.kind   <= KIND_FULL;
            res_reg.status <= ST_OK;
            res_reg.vol    <= recip_reg[VOL_SHIFT +: VOL_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_reg <= res_reg;
        end
    end

    assign sts.reject   = reject;
    assign sts.above    = above;
    assign sts.div_busy = div_busy;
    assign sts.out_free = !m_valid_reg || m_ready;

    assign m_valid         = m_valid_reg;
    assign m_update_kind   = out_reg.kind;
    assign m_distance_out  = out_reg.distance;
    assign m_level_percent = out_reg.pct;
    assign m_volume_out    = out_reg.vol;
    assign m_sensor_status = out_reg.status;
    assign m_good_lamp     = out_reg.lamp;

endmodule

### rtl/utlf_ctrl.sv
// Controller state machine that sequences one reading through the datapath.
module utlf_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output utlf_pkg::ctrl_cmd_t   cmd,
    input  utlf_pkg::dp_status_t  sts
);
    import utlf_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_MUL     = 4'd1;
    localparam logic [3:0] S_CHECK   = 4'd2;
    localparam logic [3:0] S_AVG_DIV = 4'd3;
    localparam logic [3:0] S_AVG     = 4'd4;
    localparam logic [3:0] S_PCT_DIV = 4'd5;
    localparam logic [3:0] S_PCT     = 4'd6;
    localparam logic [3:0] S_VOL     = 4'd7;
    localparam logic [3:0] S_DONE    = 4'd8;
    localparam logic [3:0] S_OUT     = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_MUL;
                end
            end
            S_MUL: begin
                cmd.mul_echo = 1'b1;
                state_next   = S_CHECK;
            end
            S_CHECK: begin
                cmd.check  = 1'b1;
                state_next = sts.reject ? S_OUT : S_AVG_DIV;
            end
            S_AVG_DIV: begin
                if (!sts.div_busy) begin
                    state_next = S_AVG;
                end
            end
            S_AVG: begin
                cmd.take_avg = 1'b1;
                state_next   = sts.above ? S_OUT : S_PCT_DIV;
            end
            S_PCT_DIV: begin
                if (!sts.div_busy) begin
                    state_next = S_PCT;
                end
            end
            S_PCT: begin
                cmd.take_pct = 1'b1;
                state_next   = S_VOL;
            end
            S_VOL: begin
                cmd.mul_recip = 1'b1;
                state_next    = S_DONE;
            end
            S_DONE: begin
                cmd.finish = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = state_reg == S_IDLE;

endmodule

### rtl/ultrasonic_tank_level_filter_top.sv
// Top level of the ultrasonic tank level filter: controller and datapath.
//
//   Channel   Direction   Handshake           Beat contents
//   s_        in          s_valid / s_ready   s_echo_time
//   m_        out         m_valid / m_ready   update kind, distance, level, volume,
//                                             sensor status, good lamp
//   cfg_      in          cfg_wen             cfg_index, cfg_wdata
//
// A rejected reading goes from the check to the output stage; one above the tank
// height also passes the average divide; a full update both divides and the volume
// multiply. The output stage waits while the last beat is held. The shared serial
// divider takes 12 steps for the average and 7 for the level percent. The result
// register holds one beat while the next reading is accepted. Reset is synchronous
// and active low; it restores register defaults and empties the averaging window.
module ultrasonic_tank_level_filter_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wen,
    input  logic [utlf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [utlf_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [utlf_pkg::ECHO_W-1:0]        s_echo_time,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [utlf_pkg::KIND_W-1:0]        m_update_kind,
    output logic [utlf_pkg::DIST_W-1:0]        m_distance_out,
    output logic [utlf_pkg::PCT_W-1:0]         m_level_percent,
    output logic [utlf_pkg::VOL_W-1:0]         m_volume_out,
    output logic [utlf_pkg::STATUS_W-1:0]      m_sensor_status,
    output logic                               m_good_lamp
);
    import utlf_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t sts;

    utlf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    utlf_dpath u_dpath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wen         (cfg_wen),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_echo_time     (s_echo_time),
        .cmd             (cmd),
        .sts             (sts),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_update_kind   (m_update_kind),
        .m_distance_out  (m_distance_out),
        .m_level_percent (m_level_percent),
        .m_volume_out    (m_volume_out),
        .m_sensor_status (m_sensor_status),
        .m_good_lamp     (m_good_lamp)
    );

endmodule
